### rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SMA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition that must never be seen outside reset
`define SMA_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

### rtl/sma_pkg.sv
// ---------------------------------------------------------------------------
// sma_pkg
// Constants shared by the moving average datapath and its testbench, window sizing included.
// ---------------------------------------------------------------------------
`default_nettype none

package sma_pkg;

    // window store geometry
    localparam int WINDOW_DEPTH = 256;
    localparam int PTR_BITS     = $clog2(WINDOW_DEPTH);
    localparam int LEN_BITS     = PTR_BITS + 1;

    // field widths
    localparam int SAMPLE_BITS  = 32;
    localparam int TIME_BITS    = 48;
    localparam int TOTAL_BITS   = 40;

    // divider sizing
    localparam int STEP_BITS    = $clog2(TOTAL_BITS);
    localparam int REM_BITS     = LEN_BITS + 1;

endpackage

`default_nettype wire

### rtl/sma_ram.sv
// ---------------------------------------------------------------------------
// sma_ram
// Generic single-write, single-read synchronous ram with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/simple_moving_average_top.sv
// ---------------------------------------------------------------------------
// simple_moving_average_top
// Boxcar moving average over timestamped Q16.16 samples.
// ---------------------------------------------------------------------------
// Usage:
//   input request: sample_value, sample_time, series_start on in_valid/in_ready.
//   output request: average, average_time on out_valid/out_ready.
//   window_length is written with window_length_we while the block is idle.
// Operation:
//   a request reads the oldest sample from the window ram, then updates the
//   rolling sum, stores the new sample and bumps pointer and count.
//   when the window is full the sum is divided by window_length in a
//   restoring divider that yields one quotient bit per cycle.
// Timing:
//   a sample without result passes the read and update steps; one with a result
//   also runs the divide steps and an output load, one divide step per bit of
//   the 40-bit running sum through the bit-serial divider.
//   one request is worked on at a time; the next is taken as soon as the
//   result sits in the output register, even if not yet taken.
//   if the receiver stalls with a result pending, a second result waits in
//   the divider until the output register frees up.
// Reset:
//   count, sum and pointer clear, window_length returns to 1; the ram is
//   not cleared, only entries already written are ever read back.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module simple_moving_average_top
    import sma_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration
    input  wire logic                   window_length_we,
    input  wire logic [LEN_BITS-1:0]    window_length,
    // input request
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] sample_value,
    input  wire logic [TIME_BITS-1:0]   sample_time,
    input  wire logic                   series_start,
    // output request
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [SAMPLE_BITS-1:0]      average,
    output logic [TIME_BITS-1:0]        average_time
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_OUT    = 4'b1000
    } sma_state_t;

    localparam logic [LEN_BITS-1:0]    DEPTH_LEN = LEN_BITS'(WINDOW_DEPTH);
    localparam logic [STEP_BITS-1:0]   LAST_STEP = STEP_BITS'(TOTAL_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] MEAN_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MEAN_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    sma_state_t               state_reg, state_next;
    logic [LEN_BITS-1:0]      len_reg;
    logic [LEN_BITS-1:0]      seen_reg, seen_next;
    logic [PTR_BITS-1:0]      wp_reg;
    logic [TOTAL_BITS-1:0]    total_reg, total_next;
    logic [STEP_BITS-1:0]     step_reg;
    logic                     out_valid_reg;

    // payload registers
    logic [SAMPLE_BITS-1:0]   sample_reg;
    logic [TIME_BITS-1:0]     time_reg;
    logic                     start_reg;
    logic [TOTAL_BITS-1:0]    quo_reg, quo_next;
    logic [REM_BITS-1:0]      rem_reg, rem_next;
    logic                     neg_reg;
    logic [SAMPLE_BITS-1:0]   average_reg;
    logic [TIME_BITS-1:0]     average_time_reg;

    logic                     in_fire;
    logic                     out_load;
    logic                     len_ok;
    logic [SAMPLE_BITS-1:0]   old_sample;
    logic [PTR_BITS-1:0]      old_addr;
    logic [LEN_BITS-1:0]      seen_eff;
    logic [TOTAL_BITS-1:0]    total_eff;
    logic                     remove_old;
    logic                     emit;
    logic [REM_BITS-1:0]      rem_shift;
    logic [SAMPLE_BITS-1:0]   mean_sat;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign len_ok   = (len_reg != '0) && (len_reg <= DEPTH_LEN);
    assign old_addr = wp_reg - len_reg[PTR_BITS-1:0];
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // window store: read the oldest sample on accept, write the new one on update
    sma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (state_reg == ST_UPDATE),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (in_fire),
        .rd_addr (old_addr),
        .rd_data (old_sample)
    );

    // rolling sum and count update
    always_comb
    begin
        seen_eff   = start_reg ? '0 : seen_reg;
        total_eff  = start_reg ? '0 : total_reg;
        remove_old = len_ok && (seen_eff >= len_reg);
        total_next = total_eff + TOTAL_BITS'(signed'(sample_reg));
        if (remove_old)
        begin
            total_next = total_next - TOTAL_BITS'(signed'(old_sample));
        end
        seen_next  = (seen_eff == DEPTH_LEN) ? seen_eff : seen_eff + 1'b1;
        emit       = len_ok && (seen_next >= len_reg);
    end

    // restoring divider step
    always_comb
    begin
        rem_shift = {rem_reg[REM_BITS-2:0], quo_reg[TOTAL_BITS-1]};
        if (rem_shift >= REM_BITS'(len_reg))
        begin
            rem_next = rem_shift - REM_BITS'(len_reg);
            quo_next = {quo_reg[TOTAL_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift;
            quo_next = {quo_reg[TOTAL_BITS-2:0], 1'b0};
        end
    end

    // sign restore and saturation of the quotient
    always_comb
    begin
        if (!neg_reg)
        begin
            if (quo_reg[TOTAL_BITS-1:SAMPLE_BITS-1] != '0)
            begin
                mean_sat = MEAN_MAX;
            end
            else
            begin
                mean_sat = quo_reg[SAMPLE_BITS-1:0];
            end
        end
        else
        begin
            if ((quo_reg[TOTAL_BITS-1:SAMPLE_BITS] != '0) ||
                (quo_reg[SAMPLE_BITS-1] && (quo_reg[SAMPLE_BITS-2:0] != '0)))
            begin
                mean_sat = MEAN_MIN;
            end
            else
            begin
                mean_sat = '0 - quo_reg[SAMPLE_BITS-1:0];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = emit ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_BITS'(1);
            seen_reg      <= '0;
            wp_reg        <= '0;
            total_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (window_length_we)
            begin
                len_reg <= window_length;
            end
            if (state_reg == ST_UPDATE)
            begin
                seen_reg  <= seen_next;
                total_reg <= total_next;
                wp_reg    <= wp_reg + 1'b1;
                step_reg  <= LAST_STEP;
            end
            else if (state_reg == ST_DIVIDE)
            begin
                step_reg <= step_reg - 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= sample_value;
            time_reg   <= sample_time;
            start_reg  <= series_start;
        end
        if (state_reg == ST_UPDATE)
        begin
            neg_reg <= total_next[TOTAL_BITS-1];
            quo_reg <= total_next[TOTAL_BITS-1] ? '0 - total_next : total_next;
            rem_reg <= '0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (out_load)
        begin
            average_reg      <= mean_sat;
            average_time_reg <= time_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign average      = average_reg;
    assign average_time = average_time_reg;

    // checks
    `SMA_ASSERT(a_seen_bounded, seen_reg <= DEPTH_LEN)
    `SMA_ASSERT(a_rem_below_len, (state_reg == ST_DIVIDE) |-> (rem_reg < REM_BITS'(len_reg)))
    `SMA_NEVER(a_no_overwrite, out_load && out_valid_reg && !out_ready)
    `SMA_ASSERT(a_update_after_accept, in_fire |=> (state_reg == ST_UPDATE))

endmodule

`default_nettype wire

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives timestamped Q16.16 samples into simple_moving_average_top and
// checks every window mean against a boxcar predictor kept in step with the
// accepted requests. Directed tests cover field extremes, the window filling
// up, out-of-range lengths and mean saturation. Random series follow, with
// length changes, restarts and a full 256-deep window, under varying idling.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import sma_pkg::*;

    // one window mean as it leaves the block
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic [TIME_BITS-1:0]   average_time;
    } mean_result_t;

    localparam int     DRAIN_CYCLES = 60;
    localparam longint MEAN_MAX     = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint MEAN_MIN     = -MEAN_MAX - 1;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   window_length_we;
    logic [LEN_BITS-1:0]    window_length;
    logic                   in_valid;
    logic                   in_ready;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic [TIME_BITS-1:0]   sample_time;
    logic                   series_start;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [SAMPLE_BITS-1:0] average;
    logic [TIME_BITS-1:0]   average_time;

    // idling odds in percent per cycle
    int tx_idle_pct;
    int rx_idle_pct;
    int mismatches;

    // boxcar predictor state
    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
    logic [TOTAL_BITS-1:0]  ring_sum;
    int unsigned            ring_fill;
    logic [PTR_BITS-1:0]    ring_wr;
    logic [LEN_BITS-1:0]    avg_len;
    mean_result_t           mean_expected [$];

    simple_moving_average_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .window_length_we (window_length_we),
        .window_length    (window_length),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample_value     (sample_value),
        .sample_time      (sample_time),
        .series_start     (series_start),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .average          (average),
        .average_time     (average_time)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // update the window for one accepted sample and queue its mean if due
    function automatic void predict_mean(input logic [SAMPLE_BITS-1:0] value,
                                         input logic [TIME_BITS-1:0]   stamp,
                                         input logic                   restart);
        bit                  len_ok;
        logic [PTR_BITS-1:0] old_slot;
        longint              sum_wide;
        longint              quotient;
        mean_result_t        res;

        len_ok = (avg_len >= 1) && (avg_len <= WINDOW_DEPTH);
        if (restart)
        begin
            ring_fill = 0;
            ring_sum  = '0;
        end
        ring_sum = ring_sum + {{(TOTAL_BITS-SAMPLE_BITS){value[SAMPLE_BITS-1]}}, value};
        // drop the sample that falls out of the window
        if (len_ok && ring_fill >= avg_len)
        begin
            old_slot = ring_wr - avg_len[PTR_BITS-1:0];
            ring_sum = ring_sum - {{(TOTAL_BITS-SAMPLE_BITS){ring_mem[old_slot][SAMPLE_BITS-1]}},
                                   ring_mem[old_slot]};
        end
        ring_mem[ring_wr] = value;
        ring_wr           = ring_wr + 1'b1;
        if (ring_fill < WINDOW_DEPTH)
            ring_fill++;

        // mean toward zero, clipped to the Q16.16 range
        if (len_ok && ring_fill >= avg_len)
        begin
            sum_wide = signed'(ring_sum);
            quotient = sum_wide / longint'(avg_len);
            if (quotient > MEAN_MAX)
                quotient = MEAN_MAX;
            if (quotient < MEAN_MIN)
                quotient = MEAN_MIN;
            res.average      = quotient[SAMPLE_BITS-1:0];
            res.average_time = stamp;
            mean_expected.push_back(res);
        end
    endfunction

    // mostly random samples, with extremes and small values mixed in
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] small_val;

        small_val = $urandom_range(20);
        case ($urandom_range(9))
            0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2:       return small_val - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TIME_BITS-1:0] pick_time();
        logic [63:0] raw;

        raw = {$urandom, $urandom};
        return raw[TIME_BITS-1:0];
    endfunction

    // present one sample request and hold it until accepted
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value,
                               input logic [TIME_BITS-1:0]   stamp,
                               input logic                   restart);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= value;
        sample_time  <= stamp;
        series_start <= restart;
        do
            @(posedge clk);
        while (!in_ready);
        predict_mean(value, stamp, restart);
    endtask

    // stop sending, collect every pending mean, let the datapath settle
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (mean_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_BITS-1:0] len);
        drain_block();
        @(negedge clk);
        window_length_we <= 1'b1;
        window_length    <= len;
        @(negedge clk);
        window_length_we <= 1'b0;
        avg_len = len;
    endtask

    // length of one straight after reset, field extremes
    task automatic test_reset_length();
        send_sample(32'h7FFF_FFFF, 48'h0000_0000_0000, 1'b1);
        send_sample(32'h8000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 48'h8000_0000_0001, 1'b0);
    endtask

    // no mean until four samples are in, then negative rounding toward zero
    task automatic test_window_fill();
        write_length(4);
        send_sample(32'hFFFF_FFFF, 48'd100, 1'b1);
        send_sample(32'hFFFF_FFFE, 48'd101, 1'b0);
        send_sample(32'hFFFF_FFFD, 48'd102, 1'b0);
        send_sample(32'hFFFF_FFFC, 48'd103, 1'b0);
        send_sample(32'h0000_0007, 48'd104, 1'b0);
        send_sample(32'h0001_8000, 48'd105, 1'b0);
    endtask

    // invalid lengths pile up the sum, a valid length then clips the mean
    task automatic test_length_out_of_range();
        write_length(0);
        send_sample(32'h7FFF_FFFF, 48'h0000_0000_0200, 1'b1);
        send_sample(32'h7FFF_FFFF, 48'h0000_0000_0201, 1'b0);
        send_sample(32'h7FFF_FFFF, 48'h0000_0000_0202, 1'b0);
        write_length(300);
        send_sample(32'h7FFF_FFFF, 48'h5555_5555_5555, 1'b0);
        send_sample(32'h7FFF_FFFF, 48'hAAAA_AAAA_AAAA, 1'b0);
        write_length(1);
        send_sample(32'h0000_0005, 48'h0000_0000_0205, 1'b0);
        write_length(511);
        send_sample(32'h8000_0000, 48'h0000_0000_0300, 1'b1);
        send_sample(32'h8000_0000, 48'h0000_0000_0301, 1'b0);
        send_sample(32'h8000_0000, 48'h0000_0000_0302, 1'b0);
        send_sample(32'h8000_0000, 48'h0000_0000_0303, 1'b0);
        write_length(2);
        send_sample(32'h0000_0000, 48'h0000_0000_0304, 1'b0);
    endtask

    // random series: mostly short windows, some invalid lengths and restarts
    task automatic test_random_series(input int item_budget);
        int                  sent;
        int                  n_items;
        int                  pick;
        bit                  restart;
        logic [LEN_BITS-1:0] len;

        sent = 0;
        while (sent < item_budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = LEN_BITS'($urandom_range(12, 1));
            else if (pick < 80)
                len = LEN_BITS'($urandom_range(40, 13));
            else if (pick < 88)
                len = '0;
            else if (pick < 98)
                len = LEN_BITS'($urandom_range(511, 257));
            else
                len = LEN_BITS'($urandom_range(200, 65));
            write_length(len);

            // a series without a start carries the old sum over
            restart = ($urandom_range(99) < 80);
            if (len >= 1 && len <= WINDOW_DEPTH)
                n_items = len + $urandom_range(8);
            else
                n_items = $urandom_range(8, 2);
            for (int i = 0; i < n_items; i++)
            begin
                send_sample(pick_sample(), pick_time(),
                            (i == 0 && restart) || ($urandom_range(99) < 3));
                sent++;
            end
        end
    endtask

    // deepest window, then a shorter length in the same series
    task automatic test_full_window();
        write_length(LEN_BITS'(WINDOW_DEPTH));
        for (int i = 0; i < WINDOW_DEPTH + 2; i++)
            send_sample(pick_sample(), pick_time(), i == 0);
        write_length(LEN_BITS'(WINDOW_DEPTH - 1));
        for (int i = 0; i < 6; i++)
            send_sample(pick_sample(), pick_time(), 1'b0);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        mean_result_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (mean_expected.size() == 0)
            begin
                $error("unexpected result: average %h, average_time %h",
                       average, average_time);
                mismatches++;
            end
            else
            begin
                want = mean_expected.pop_front();
                if (average !== want.average)
                begin
                    $error("average: expected %h, actual %h", want.average, average);
                    mismatches++;
                end
                if (average_time !== want.average_time)
                begin
                    $error("average_time: expected %h, actual %h",
                           want.average_time, average_time);
                    mismatches++;
                end
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n            = 1'b0;
        window_length_we = 1'b0;
        window_length    = '0;
        in_valid         = 1'b0;
        sample_value     = '0;
        sample_time      = '0;
        series_start     = 1'b0;
        mismatches       = 0;
        tx_idle_pct      = 28;
        rx_idle_pct      = 68;
        ring_sum         = '0;
        ring_fill        = 0;
        ring_wr          = '0;
        avg_len          = 1;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_length();
        test_window_fill();
        test_length_out_of_range();
        test_random_series(40);

        tx_idle_pct = 68;
        rx_idle_pct = 28;
        test_random_series(40);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_series(30);
        test_full_window();

        drain_block();
        if (mismatches == 0 && mean_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
